@@ rtl/screen_row_closest_point_core_assert.svh @@
// assertion macros used by the screen row closest point core
`ifndef SCREEN_ROW_CLOSEST_POINT_CORE_ASSERT_SVH
`define SCREEN_ROW_CLOSEST_POINT_CORE_ASSERT_SVH

// same-cycle implication
`define SRCP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/srcp_pkg.sv @@
// shared types and constants of the screen row closest point block
`default_nettype none

package srcp_pkg;

   localparam int MAX_SCREENS_DEF = 8;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 8;
   localparam int SIZE_W   = 14;
   localparam int COORD_W  = 23;
   localparam int LOCAL_W  = 18;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 4;
   localparam int FRAC_W   = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_DUP       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TBL_IDLE,
      TBL_INSERT,
      TBL_DELETE,
      TBL_SET_LEFT
   } tbl_op_type;

   // left edge in pixels holds a sum of up to max_screens-1 widths
   function automatic int left_width(input int max_screens);
      left_width = SIZE_W + $clog2(max_screens);
   endfunction

endpackage

`default_nettype wire

@@ rtl/srcp_slot_table.sv @@
// ordered screen slot table with front insert, delete-with-close and left edge write
`default_nettype none

module srcp_slot_table import srcp_pkg::*; #(
   parameter int MAX_SCREENS = MAX_SCREENS_DEF,
   parameter int IDX_W       = 3,
   parameter int LEFT_W      = 17
) (
   input  logic              clock,
   input  tbl_op_type        op,
   input  logic [IDX_W-1:0]  idx,
   input  logic [ID_W-1:0]   new_id,
   input  logic [SIZE_W-1:0] new_width,
   input  logic [SIZE_W-1:0] new_height,
   input  logic [LEFT_W-1:0] new_left,
   output logic [ID_W-1:0]   rd_id,
   output logic [SIZE_W-1:0] rd_width,
   output logic [SIZE_W-1:0] rd_height,
   output logic [LEFT_W-1:0] rd_left
);

   logic [ID_W-1:0]   id_ff     [MAX_SCREENS];
   logic [SIZE_W-1:0] width_ff  [MAX_SCREENS];
   logic [SIZE_W-1:0] height_ff [MAX_SCREENS];
   logic [LEFT_W-1:0] left_ff   [MAX_SCREENS];

   always_ff @(posedge clock) begin
      unique case (op)
         TBL_INSERT: begin
            // every entry moves one place back, new screen goes in front
            for (int j = 1; j < MAX_SCREENS; j++) begin
               id_ff[j]     <= id_ff[j-1];
               width_ff[j]  <= width_ff[j-1];
               height_ff[j] <= height_ff[j-1];
            end
            id_ff[0]     <= new_id;
            width_ff[0]  <= new_width;
            height_ff[0] <= new_height;
         end
         TBL_DELETE: begin
            // entries from the removed slot on close the gap
            for (int j = 0; j < MAX_SCREENS - 1; j++) begin
               if (IDX_W'(j) >= idx) begin
                  id_ff[j]     <= id_ff[j+1];
                  width_ff[j]  <= width_ff[j+1];
                  height_ff[j] <= height_ff[j+1];
               end
            end
         end
         TBL_SET_LEFT: begin
            left_ff[idx] <= new_left;
         end
         TBL_IDLE: begin
         end
      endcase
   end

   assign rd_id     = id_ff[idx];
   assign rd_width  = width_ff[idx];
   assign rd_height = height_ff[idx];
   assign rd_left   = left_ff[idx];

endmodule

`default_nettype wire

@@ rtl/srcp_dist_unit.sv @@
// pipelined clamp, squared distance and running best-screen unit
`default_nettype none

module srcp_dist_unit import srcp_pkg::*; #(
   parameter int LEFT_W = 17,
   parameter int CW     = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic                      in_first,
   input  logic                      in_last,
   input  logic signed [COORD_W-1:0] qx,
   input  logic signed [COORD_W-1:0] qy,
   input  logic [LEFT_W-1:0]         left,
   input  logic [SIZE_W-1:0]         width,
   input  logic [SIZE_W-1:0]         height,
   input  logic [ID_W-1:0]           id,
   output logic                      done,
   output logic [ID_W-1:0]           best_id,
   output logic [LOCAL_W-1:0]        best_lx,
   output logic [LOCAL_W-1:0]        best_ly
);

   localparam int SQ_W = 2 * CW - 1;
   localparam int D_W  = 2 * CW;

   logic signed [CW-1:0] qx_s, qy_s, left16, right16, bottom16;
   logic signed [CW-1:0] cx, cy, dx, dy, lx_full;

   logic                 s1_valid_ff, s1_first_ff, s1_last_ff;
   logic signed [CW-1:0] s1_dx_ff, s1_dy_ff;
   logic [LOCAL_W-1:0]   s1_lx_ff, s1_ly_ff;
   logic [ID_W-1:0]      s1_id_ff;

   logic                 s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [SQ_W-1:0]      s2_sqx_ff, s2_sqy_ff;
   logic [LOCAL_W-1:0]   s2_lx_ff, s2_ly_ff;
   logic [ID_W-1:0]      s2_id_ff;

   logic signed [2*CW-1:0] prod_x, prod_y;
   logic [D_W-1:0]         dist_sum;
   logic                   take;

   logic [D_W-1:0]     best_d_ff;
   logic [ID_W-1:0]    best_id_ff;
   logic [LOCAL_W-1:0] best_lx_ff, best_ly_ff;
   logic               done_ff;

   // box edges in fixed point, all non-negative
   always_comb begin
      qx_s     = CW'(qx);
      qy_s     = CW'(qy);
      left16   = CW'({1'b0, left, {FRAC_W{1'b0}}});
      right16  = CW'({(LEFT_W + 1)'(left) + (LEFT_W + 1)'(width), {FRAC_W{1'b0}}});
      bottom16 = CW'({height, {FRAC_W{1'b0}}});

      if (qx_s < left16) begin
         cx = left16;
      end else if (qx_s > right16) begin
         cx = right16;
      end else begin
         cx = qx_s;
      end

      if (qy_s[CW-1]) begin
         cy = '0;
      end else if (qy_s > bottom16) begin
         cy = bottom16;
      end else begin
         cy = qy_s;
      end

      dx      = qx_s - cx;
      dy      = qy_s - cy;
      lx_full = cx - left16;
   end

   assign prod_x   = s1_dx_ff * s1_dx_ff;
   assign prod_y   = s1_dy_ff * s1_dy_ff;
   assign dist_sum = D_W'(s2_sqx_ff) + D_W'(s2_sqy_ff);
   // first slot always wins, later ones only when strictly closer
   assign take     = s2_valid_ff && (s2_first_ff || (dist_sum < best_d_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_last_ff;
      end

      s1_first_ff <= in_first;
      s1_last_ff  <= in_last;
      s1_dx_ff    <= dx;
      s1_dy_ff    <= dy;
      s1_lx_ff    <= lx_full[LOCAL_W-1:0];
      s1_ly_ff    <= cy[LOCAL_W-1:0];
      s1_id_ff    <= id;

      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_sqx_ff   <= prod_x[SQ_W-1:0];
      s2_sqy_ff   <= prod_y[SQ_W-1:0];
      s2_lx_ff    <= s1_lx_ff;
      s2_ly_ff    <= s1_ly_ff;
      s2_id_ff    <= s1_id_ff;

      if (take) begin
         best_d_ff  <= dist_sum;
         best_id_ff <= s2_id_ff;
         best_lx_ff <= s2_lx_ff;
         best_ly_ff <= s2_ly_ff;
      end
   end

   assign done    = done_ff;
   assign best_id = best_id_ff;
   assign best_lx = best_lx_ff;
   assign best_ly = best_ly_ff;

endmodule

`default_nettype wire

@@ rtl/screen_row_closest_point_core.sv @@
// screen row closest point: top level with command sequencer
//
// Keeps an ordered row of up to MAX_SCREENS screens laid out left to right at y=0.
// Command channel: a command is transferred at a clock edge where start is high
// and busy is low; req_command selects add (front insert), remove by id, or a
// closest-point query. Exactly one result per command is shown on the rsp_ ports
// for one cycle with rsp_valid high; the receiver cannot stall it.
// Steps from transfer to result strobe:
//   query:           one slot a cycle through the 3-stage distance unit
//   add / remove:    id search, table edit, left-edge re-layout (search and
//                    re-layout walk one slot a cycle through the single read port)
//   rejected edit:   at most the id search;  unused command or empty query: answered from idle
// busy stays high from transfer until the result strobe unless answered from idle; one command at a time.
// Reset (synchronous, active high) empties the table; stored screen data is not
// cleared, only the screen count.
`default_nettype none
`include "screen_row_closest_point_core_assert.svh"

module screen_row_closest_point_core import srcp_pkg::*; #(
   parameter int MAX_SCREENS = MAX_SCREENS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [ID_W-1:0]           req_screen_id,
   input  logic [SIZE_W-1:0]         req_screen_width,
   input  logic [SIZE_W-1:0]         req_screen_height,
   input  logic signed [COORD_W-1:0] req_query_x,
   input  logic signed [COORD_W-1:0] req_query_y,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_found,
   output logic [ID_W-1:0]           rsp_closest_id,
   output logic [LOCAL_W-1:0]        rsp_local_x,
   output logic [LOCAL_W-1:0]        rsp_local_y,
   output logic [TOTAL_W-1:0]        rsp_screen_total
);

   localparam int IDX_W  = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
   localparam int CNT_W  = $clog2(MAX_SCREENS + 1);
   localparam int LEFT_W = left_width(MAX_SCREENS);
   localparam int CW     = (LEFT_W + 6 > COORD_W + 1) ? LEFT_W + 6 : COORD_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_EDIT,
      S_LAYOUT,
      S_QUERY,
      S_WAIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [CMD_W-1:0]          cmd_ff;
   logic [ID_W-1:0]           id_ff;
   logic [SIZE_W-1:0]         width_ff, height_ff;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      hit_ff, hit_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [LEFT_W-1:0]         acc_ff, acc_in;
   logic                      latch;

   logic                      resp;
   status_type                status_in;
   logic                      found_in;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic                      rsp_found_ff;
   logic [ID_W-1:0]           rsp_id_ff;
   logic [LOCAL_W-1:0]        rsp_lx_ff, rsp_ly_ff;
   logic [TOTAL_W-1:0]        rsp_total_ff;

   tbl_op_type                tbl_op;
   logic [ID_W-1:0]           rd_id;
   logic [SIZE_W-1:0]         rd_width, rd_height;
   logic [LEFT_W-1:0]         rd_left;
   logic                      idx_last;

   logic                      dist_done;
   logic [ID_W-1:0]           best_id;
   logic [LOCAL_W-1:0]        best_lx, best_ly;

   srcp_slot_table #(
      .MAX_SCREENS (MAX_SCREENS),
      .IDX_W       (IDX_W),
      .LEFT_W      (LEFT_W)
   ) u_table (
      .clock      (clock),
      .op         (tbl_op),
      .idx        (idx_ff),
      .new_id     (id_ff),
      .new_width  (width_ff),
      .new_height (height_ff),
      .new_left   (acc_ff),
      .rd_id      (rd_id),
      .rd_width   (rd_width),
      .rd_height  (rd_height),
      .rd_left    (rd_left)
   );

   srcp_dist_unit #(
      .LEFT_W (LEFT_W),
      .CW     (CW)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (state_ff == S_QUERY),
      .in_first (idx_ff == '0),
      .in_last  (idx_last),
      .qx       (qx_ff),
      .qy       (qy_ff),
      .left     (rd_left),
      .width    (rd_width),
      .height   (rd_height),
      .id       (rd_id),
      .done     (dist_done),
      .best_id  (best_id),
      .best_lx  (best_lx),
      .best_ly  (best_ly)
   );

   assign idx_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      latch     = 1'b0;
      resp      = 1'b0;
      status_in = ST_OK;
      found_in  = 1'b0;
      tbl_op    = TBL_IDLE;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               latch  = 1'b1;
               idx_in = '0;
               hit_in = 1'b0;
               acc_in = '0;
               unique case (req_command)
                  CMD_ADD, CMD_REMOVE: begin
                     state_in = (count_ff == '0) ? S_EDIT : S_FIND;
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        resp = 1'b1;
                     end else begin
                        state_in = S_QUERY;
                     end
                  end
                  default: begin
                     resp = 1'b1;
                  end
               endcase
            end
         end
         S_FIND: begin
            // a hit leaves idx on the matching slot for the delete
            if (rd_id == id_ff) begin
               hit_in   = 1'b1;
               state_in = S_EDIT;
            end else if (idx_last) begin
               state_in = S_EDIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_EDIT: begin
            idx_in = '0;
            acc_in = '0;
            if (cmd_ff == CMD_ADD) begin
               if (hit_ff) begin
                  resp      = 1'b1;
                  status_in = ST_DUP;
               end else if (count_ff == CNT_W'(MAX_SCREENS)) begin
                  resp      = 1'b1;
                  status_in = ST_FULL;
               end else begin
                  tbl_op   = TBL_INSERT;
                  count_in = count_ff + CNT_W'(1);
                  state_in = S_LAYOUT;
               end
            end else begin
               if (!hit_ff) begin
                  resp      = 1'b1;
                  status_in = ST_NOT_FOUND;
               end else begin
                  tbl_op   = TBL_DELETE;
                  count_in = count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     resp = 1'b1;
                  end else begin
                     state_in = S_LAYOUT;
                  end
               end
            end
         end
         S_LAYOUT: begin
            // running sum of widths gives each left edge
            tbl_op = TBL_SET_LEFT;
            acc_in = acc_ff + LEFT_W'(rd_width);
            if (idx_last) begin
               resp = 1'b1;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_QUERY: begin
            if (idx_last) begin
               state_in = S_WAIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_WAIT: begin
            if (dist_done) begin
               resp     = 1'b1;
               found_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (resp) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= resp;
      end

      idx_ff <= idx_in;
      hit_ff <= hit_in;
      acc_ff <= acc_in;

      if (latch) begin
         cmd_ff    <= req_command;
         id_ff     <= req_screen_id;
         width_ff  <= req_screen_width;
         height_ff <= req_screen_height;
         qx_ff     <= req_query_x;
         qy_ff     <= req_query_y;
      end

      if (resp) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_id_ff     <= found_in ? best_id : '0;
         rsp_lx_ff     <= found_in ? best_lx : '0;
         rsp_ly_ff     <= found_in ? best_ly : '0;
         rsp_total_ff  <= TOTAL_W'(count_in);
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_closest_id   = rsp_id_ff;
   assign rsp_local_x      = rsp_lx_ff;
   assign rsp_local_y      = rsp_ly_ff;
   assign rsp_screen_total = rsp_total_ff;

   `SRCP_ASSERT_IMPLY(a_rsp_in_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE, "result strobe while sequencer busy")
   `SRCP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_SCREENS), "screen count above table depth")
   `SRCP_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid_ff, "transferred command neither started nor answered")
   `SRCP_ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid_ff && rsp_found_ff, rsp_status_ff == ST_OK, "found result with error status")

endmodule

`default_nettype wire
